[rtl/core/sclr_pkg.sv]
package sclr_pkg;

    // default shuffle table depth
    localparam int TABLE_ENTRIES_DEF = 32;

    // generator moduli, multipliers and the fold constants 2^31 - modulus
    localparam logic [31:0] MOD_A       = 32'd2147483563;
    localparam logic [31:0] MOD_B       = 32'd2147483399;
    localparam logic [15:0] MUL_A       = 16'd40014;
    localparam logic [15:0] MUL_B       = 16'd40692;
    localparam logic [7:0]  FOLD_A      = 8'd85;
    localparam logic [7:0]  FOLD_B      = 8'd249;
    localparam logic [30:0] WRAP_ADD    = 31'd2147483562;
    localparam logic [30:0] SEED_RESET  = 31'd1;
    localparam logic [30:0] SECOND_RST  = 31'd123456789;
    localparam int          DISCARDS    = 8;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic seed_load;
        logic warm_upd;
        logic draw_upd;
        logic draw_load;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic warm_last;
    } t_sts;

endpackage

[rtl/core/shuffled_combined_lcg_rng_top.sv]
// shuffled combined-generator random source with range scaling
//
// input channel: i_in_valid / o_in_stall carry one word of range bounds
// (i_range_low, i_range_high). output channel: o_out_valid / i_out_stall
// carry one word (o_scaled_value, o_raw_draw) per input word.
// a word moves at a clock edge where valid is high and stall is low.
// config: i_cfg_we writes the seed from i_cfg_data; a zero seed acts as one
// and the next request re-seeds the generators and refills the table.
// a normal request runs the generator step, the table access and the quotient fold;
// a request that needs the warm-up first runs the seed load and the table fill.
// the single-entry sequencer takes no new request until the current word has
// been loaded into the output register.
// a finished word sits in the output register; the next request is taken
// while it waits, and only the final load waits for the receiver.
// reset: seed back to one, warm-up pending, no output pending.
module shuffled_combined_lcg_rng_top #(
    parameter int TABLE_ENTRIES = sclr_pkg::TABLE_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_range_low,
    input  logic signed [31:0] i_range_high,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_scaled_value,
    output logic [30:0]        o_raw_draw,
    input  logic               i_cfg_we,
    input  logic [30:0]        i_cfg_data
);

    // command and status between sequencer and datapath
    sclr_pkg::t_cmd w_cmd;
    sclr_pkg::t_sts w_sts;

    // sequencer: warm-up loop, draw steps and output hand-off
    sclr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // datapath: two generators, shuffle table memory, scaling
    sclr_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_range_low    (i_range_low),
        .i_range_high   (i_range_high),
        .o_scaled_value (o_scaled_value),
        .o_raw_draw     (o_raw_draw)
    );

    // an accepted word closes the input until its result is loaded
    a_accept_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input still open after accepting a word");

    // the output register is never overwritten while a word is held
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_out_valid || !i_out_stall))
        else $error("output loaded while a word is still held");

    // a shown draw always lies in the wrapped range
    a_draw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_raw_draw != '0) && (o_raw_draw <= sclr_pkg::WRAP_ADD)))
        else $error("raw draw outside its range");

    // the output is only loaded while the input side is closed
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> o_in_stall)
        else $error("output loaded with no word in flight");

endmodule

[rtl/core/sclr_ctrl.sv]
module sclr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  logic             i_cfg_we,
    input  sclr_pkg::t_sts   i_sts,
    output sclr_pkg::t_cmd   o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SEED = 4'd1;
    localparam logic [3:0] S_WMUL = 4'd2;
    localparam logic [3:0] S_WRED = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_RED  = 4'd5;
    localparam logic [3:0] S_DRAW = 4'd6;
    localparam logic [3:0] S_PROD = 4'd7;
    localparam logic [3:0] S_DIV1 = 4'd8;
    localparam logic [3:0] S_DIV2 = 4'd9;
    localparam logic [3:0] S_DIV3 = 4'd10;
    localparam logic [3:0] S_FIN  = 4'd11;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       r_warm, n_warm;
    sclr_pkg::t_cmd w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.capture = 1'b1;
                    n_state = r_warm ? S_SEED : S_RED;
                end
            end
            S_SEED: begin
                w_cmd.seed_load = 1'b1;
                n_state = S_WMUL;
            end
            S_WMUL: n_state = S_WRED;
            S_WRED: begin
                w_cmd.warm_upd = 1'b1;
                n_state = i_sts.warm_last ? S_MUL : S_WMUL;
            end
            S_MUL:  n_state = S_RED;
            S_RED: begin
                w_cmd.draw_upd = 1'b1;
                n_state = S_DRAW;
            end
            S_DRAW: begin
                w_cmd.draw_load = 1'b1;
                n_state = S_PROD;
            end
            S_PROD: n_state = S_DIV1;
            S_DIV1: n_state = S_DIV2;
            S_DIV2: n_state = S_DIV3;
            S_DIV3: n_state = S_FIN;
            S_FIN: begin
                // wait here while the previous word is still held
                if (!r_out_valid || !i_out_stall) begin
                    w_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = w_cmd.out_load || (r_out_valid && i_out_stall);
        n_warm      = r_warm;
        if (w_cmd.seed_load) begin
            n_warm = 1'b0;
        end
        if (i_cfg_we) begin
            n_warm = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_warm      <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_warm      <= n_warm;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule

[rtl/core/sclr_dp.sv]
module sclr_dp #(
    parameter int TABLE_ENTRIES = sclr_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sclr_pkg::t_cmd      i_cmd,
    output sclr_pkg::t_sts      o_sts,
    input  logic                i_cfg_we,
    input  logic [30:0]         i_cfg_data,
    input  logic signed [31:0]  i_range_low,
    input  logic signed [31:0]  i_range_high,
    output logic signed [31:0]  o_scaled_value,
    output logic [30:0]         o_raw_draw
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + sclr_pkg::DISCARDS);
    localparam longint unsigned SLOT_DIV =
        64'd1 + 64'(sclr_pkg::WRAP_ADD) / 64'(TABLE_ENTRIES);

    // generator and shuffle state
    logic [30:0] r_seed;
    logic [30:0] r_gen1;
    logic [30:0] r_gen2;
    logic [30:0] r_shuf;
    logic [CW-1:0] r_cnt;

    // generator step: product, then fold of the top bits
    logic [46:0] r_pa;
    logic [46:0] r_pb;
    logic [31:0] w_sum_a, w_sum_b;
    logic [30:0] w_red_a, w_red_b;

    // slot selection
    logic [TABLE_ENTRIES-1:1] w_ge;
    logic [TABLE_ENTRIES-1:1] r_therm;
    logic [TABLE_ENTRIES:1]   w_th_ext;
    logic [AW-1:0]            w_slot;

    // table
    logic [30:0]   r_tbl [TABLE_ENTRIES];
    logic [30:0]   r_rd;
    logic          w_we;
    logic [AW-1:0] w_wa;

    // draw and scaling
    logic [32:0] w_diff;
    logic [30:0] w_draw;
    logic [31:0] r_lo;
    logic [32:0] r_dif;
    logic [31:0] r_mag;
    logic        r_neg;
    logic [62:0] r_prod;
    logic [39:0] r_x1;
    logic [31:0] r_q1;
    logic [31:0] r_x2;
    logic [31:0] r_q2;
    logic [31:0] r_q;
    logic [31:0] r_out_scaled;
    logic [30:0] r_out_raw;
    logic [30:0] w_seed_eff;

    always_comb begin
        w_sum_a = 32'(r_pa[30:0]) + 32'(r_pa[46:31]) * 32'(sclr_pkg::FOLD_A);
        w_sum_b = 32'(r_pb[30:0]) + 32'(r_pb[46:31]) * 32'(sclr_pkg::FOLD_B);
        w_red_a = (w_sum_a >= sclr_pkg::MOD_A) ? 31'(w_sum_a - sclr_pkg::MOD_A)
                                                : w_sum_a[30:0];
        w_red_b = (w_sum_b >= sclr_pkg::MOD_B) ? 31'(w_sum_b - sclr_pkg::MOD_B)
                                                : w_sum_b[30:0];
    end

    for (genvar k = 1; k < TABLE_ENTRIES; k++) begin : g_thr
        localparam logic [30:0] THR = 31'(64'(k) * SLOT_DIV);
        assign w_ge[k] = (r_shuf >= THR);
    end

    // thermometer to binary: the last set bit gives the slot
    always_comb begin
        w_th_ext = {1'b0, r_therm};
        w_slot   = '0;
        for (int k = 1; k < TABLE_ENTRIES; k++) begin
            if (w_th_ext[k] && !w_th_ext[k+1]) begin
                w_slot = w_slot | AW'(k);
            end
        end
    end

    assign w_we = (i_cmd.warm_upd && (r_cnt < CW'(TABLE_ENTRIES))) || i_cmd.draw_upd;
    assign w_wa = i_cmd.warm_upd ? r_cnt[AW-1:0] : w_slot;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_tbl[w_wa] <= w_red_a;
        end
        r_rd <= r_tbl[w_slot];
    end

    always_comb begin
        w_diff = {2'b00, r_rd} - {2'b00, r_gen2};
        if (w_diff[32] || (w_diff == '0)) begin
            w_draw = 31'(w_diff + {2'b00, sclr_pkg::WRAP_ADD});
        end else begin
            w_draw = w_diff[30:0];
        end
        w_seed_eff = (i_cfg_data == '0) ? sclr_pkg::SEED_RESET : i_cfg_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= sclr_pkg::SEED_RESET;
            r_gen1 <= '0;
            r_gen2 <= sclr_pkg::SECOND_RST;
            r_shuf <= '0;
        end else begin
            if (i_cfg_we) begin
                r_seed <= w_seed_eff;
            end
            if (i_cmd.seed_load) begin
                r_gen1 <= r_seed;
                r_gen2 <= r_seed;
            end else if (i_cmd.warm_upd) begin
                r_gen1 <= w_red_a;
                if (r_cnt == '0) begin
                    r_shuf <= w_red_a;
                end
            end else if (i_cmd.draw_upd) begin
                r_gen1 <= w_red_a;
                r_gen2 <= w_red_b;
            end else if (i_cmd.draw_load) begin
                r_shuf <= w_draw;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.seed_load) begin
            r_cnt <= CW'(TABLE_ENTRIES + sclr_pkg::DISCARDS - 1);
        end else if (i_cmd.warm_upd) begin
            r_cnt <= r_cnt - CW'(1);
        end
        if (i_cmd.capture) begin
            r_lo  <= i_range_low;
            r_dif <= {i_range_high[31], i_range_high} - {i_range_low[31], i_range_low};
        end
        if (i_cmd.out_load) begin
            r_out_scaled <= r_neg ? (r_lo - r_q) : (r_lo + r_q);
            r_out_raw    <= r_shuf;
        end
    end

    // free-running stages, sequenced by the controller
    always_ff @(posedge i_clk) begin
        r_pa    <= 47'(r_gen1) * 47'(sclr_pkg::MUL_A);
        r_pb    <= 47'(r_gen2) * 47'(sclr_pkg::MUL_B);
        r_therm <= w_ge;
        r_neg   <= r_dif[32];
        r_mag   <= r_dif[32] ? 32'(-r_dif) : r_dif[31:0];
        r_prod  <= 63'(r_mag) * 63'(r_shuf);
        // quotient by the modulus: fold 2^31 = modulus + 85 twice
        r_x1    <= 40'(r_prod[30:0]) + 40'(r_prod[62:31]) * 40'(sclr_pkg::FOLD_A);
        r_q1    <= r_prod[62:31];
        r_x2    <= 32'(r_x1[30:0]) + 32'(r_x1[39:31]) * 32'(sclr_pkg::FOLD_A);
        r_q2    <= r_q1 + 32'(r_x1[39:31]);
        r_q     <= r_q2 + 32'(r_x2 >= sclr_pkg::MOD_A);
    end

    assign o_sts.warm_last = (r_cnt == '0);
    assign o_scaled_value  = r_out_scaled;
    assign o_raw_draw      = r_out_raw;

endmodule

[tb/sv/lcg_draw_checker.sv]
`timescale 1ns / 1ps

module lcg_draw_checker #(
    parameter int TABLE_ENTRIES = sclr_pkg::TABLE_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic signed [31:0] i_range_low,
    input  logic signed [31:0] i_range_high,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_scaled_value,
    input  logic [30:0]        i_raw_draw,
    input  logic               i_cfg_we,
    input  logic [30:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_outstanding
);

    typedef struct packed {
        logic signed [31:0] scaled;
        logic [30:0]        raw;
    } t_draw;

    localparam longint      DRAW_MODULUS = longint'({32'd0, sclr_pkg::MOD_A});
    localparam longint      WRAP_SPAN    = longint'({33'd0, sclr_pkg::WRAP_ADD});
    localparam int unsigned SLOT_DIV     = 1 + sclr_pkg::WRAP_ADD / TABLE_ENTRIES;

    // predicted generator state
    logic [30:0] seed_q;
    logic [30:0] gen_a;
    logic [30:0] gen_b;
    logic [30:0] last_draw;
    logic [30:0] shuffle_tbl [TABLE_ENTRIES];
    bit          reseed_due;

    t_draw pending_draws[$];

    function automatic logic [30:0] lcg_advance(input logic [30:0] x, input logic [15:0] mul,
                                                input logic [31:0] modulus);
        longint unsigned prod;
        prod = 64'(x) * 64'(mul);
        return 31'(prod % 64'(modulus));
    endfunction

    function automatic t_draw next_draw(input logic signed [31:0] lo,
                                        input logic signed [31:0] hi);
        t_draw       w;
        logic [30:0] s;
        int          slot;
        longint      diff;
        longint      span;
        if (reseed_due) begin
            s     = (seed_q == 31'd0) ? 31'd1 : seed_q;
            gen_a = s;
            gen_b = s;
            // first DISCARDS steps thrown away, the rest fill top slot down
            for (int i = TABLE_ENTRIES + sclr_pkg::DISCARDS - 1; i >= 0; i--) begin
                gen_a = lcg_advance(gen_a, sclr_pkg::MUL_A, sclr_pkg::MOD_A);
                if (i < TABLE_ENTRIES)
                    shuffle_tbl[i] = gen_a;
            end
            last_draw  = shuffle_tbl[0];
            reseed_due = 1'b0;
        end
        gen_a = lcg_advance(gen_a, sclr_pkg::MUL_A, sclr_pkg::MOD_A);
        gen_b = lcg_advance(gen_b, sclr_pkg::MUL_B, sclr_pkg::MOD_B);
        slot = int'(last_draw / SLOT_DIV);
        if (slot >= TABLE_ENTRIES)
            slot = TABLE_ENTRIES - 1;
        diff = longint'({33'd0, shuffle_tbl[slot]}) - longint'({33'd0, gen_b});
        shuffle_tbl[slot] = gen_a;
        if (diff < 1)
            diff += WRAP_SPAN;
        last_draw = 31'(diff);
        span      = longint'(hi) - longint'(lo);
        w.raw     = last_draw;
        w.scaled  = 32'(longint'(lo) + (span * diff) / DRAW_MODULUS);
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_draw want;
        if (!i_rst_n) begin
            seed_q     = sclr_pkg::SEED_RESET;
            gen_a      = 31'd0;
            gen_b      = sclr_pkg::SECOND_RST;
            last_draw  = 31'd0;
            reseed_due = 1'b1;
            foreach (shuffle_tbl[k])
                shuffle_tbl[k] = 31'd0;
            pending_draws.delete();
        end else begin
            if (i_cfg_we) begin
                seed_q     = i_cfg_data;
                reseed_due = 1'b1;
            end
            if (i_in_valid && !i_in_stall)
                pending_draws.push_back(next_draw(i_range_low, i_range_high));
            if (i_out_valid && !i_out_stall) begin
                if (pending_draws.size() == 0) begin
                    $error("unexpected word: scaled_value %0d raw_draw %0d",
                           i_scaled_value, i_raw_draw);
                    o_fail_count++;
                end else begin
                    want = pending_draws.pop_front();
                    if (want.scaled !== i_scaled_value) begin
                        $error("scaled_value: expected %0d, actual %0d",
                               want.scaled, i_scaled_value);
                        o_fail_count++;
                    end
                    if (want.raw !== i_raw_draw) begin
                        $error("raw_draw: expected %0d, actual %0d", want.raw, i_raw_draw);
                        o_fail_count++;
                    end
                end
            end
        end
        o_outstanding <= pending_draws.size();
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    // bounds at the ends of the signed 32-bit range
    localparam logic signed [31:0] RANGE_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] RANGE_MAX = 32'sh7FFF_FFFF;

    // random phases, each starting from a fresh seed
    localparam int RANDOM_PHASES    = 8;
    localparam int RANDOM_PER_PHASE = 68;

    // cycles with no word moving on either channel before the run is abandoned
    localparam int QUIET_LIMIT = 2000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic signed [31:0] i_range_low;
    logic signed [31:0] i_range_high;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [31:0] o_scaled_value;
    logic [30:0]        o_raw_draw;
    logic               i_cfg_we;
    logic [30:0]        i_cfg_data;

    int fail_count;
    int outstanding;
    int quiet_cycles = 0;
    int burst_left   = 0;
    int gap;

    shuffled_combined_lcg_rng_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_range_low    (i_range_low),
        .i_range_high   (i_range_high),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_scaled_value (o_scaled_value),
        .o_raw_draw     (o_raw_draw),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    // watches both channels and the seed port, predicts every draw and compares
    lcg_draw_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_range_low    (i_range_low),
        .i_range_high   (i_range_high),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_scaled_value (o_scaled_value),
        .i_raw_draw     (o_raw_draw),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // sender works in bursts; a gap of zero lets two bursts run together
    task automatic pace();
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                // payload is junk while valid is low
                i_in_valid   <= 1'b0;
                i_range_low  <= $urandom;
                i_range_high <= $urandom;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    // one request word, held until the block takes it
    task automatic send_word(input logic signed [31:0] lo, input logic signed [31:0] hi);
        pace();
        i_in_valid   <= 1'b1;
        i_range_low  <= lo;
        i_range_high <= hi;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // stop sending and wait for every predicted word to come back
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // seed write while idle; optionally overwrite a decoy seed first,
    // so only the last of two back-to-back writes should count
    task automatic load_seed(input logic [30:0] seed, input logic [30:0] decoy,
                             input bit with_decoy);
        i_cfg_we <= 1'b1;
        if (with_decoy) begin
            i_cfg_data <= decoy;
            @(posedge i_clk);
        end
        i_cfg_data <= seed;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        i_cfg_data <= 31'($urandom);
    endtask

    // mix of full-range, narrow, reversed, symmetric and corner bounds
    task automatic random_bounds(output logic signed [31:0] lo, output logic signed [31:0] hi);
        int unsigned pick;
        pick = $urandom_range(0, 9);
        case (pick)
            5: begin
                lo = $urandom;
                hi = lo + $urandom_range(0, 1000);
            end
            6: begin
                // reversed: high below low
                hi = $urandom;
                lo = hi + $urandom_range(1, 1000);
            end
            7: begin
                lo = $urandom_range(0, 2000) - 1000;
                hi = -lo;
            end
            8, 9: begin
                lo = $urandom_range(0, 1) ? RANGE_MIN : RANGE_MAX;
                hi = $urandom_range(0, 1) ? RANGE_MAX : RANGE_MIN + $urandom_range(0, 3);
            end
            default: begin
                lo = $urandom;
                hi = $urandom;
            end
        endcase
    endtask

    // receiver stall pattern: stretches of no stall, light stall, heavy stall
    // and solid stall, each of random length
    initial begin : stall_pattern
        int mode;
        int span;
        i_out_stall <= 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 60);
            repeat (span) begin
                @(posedge i_clk);
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 99) < 30);
                    2:       i_out_stall <= ($urandom_range(0, 99) < 75);
                    default: i_out_stall <= 1'b1;
                endcase
            end
        end
    end

    // watchdog: any word moving on either channel resets the count
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("shuffled_combined_lcg_rng_top: mismatch");
            $finish;
        end
    end

    initial begin : stimulus
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic [30:0]        seed;

        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_range_low  <= '0;
        i_range_high <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_data   <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset seed of one; first word runs the warm-up
        send_word(RANGE_MIN, RANGE_MAX);
        send_word(RANGE_MAX, RANGE_MIN);
        send_word(32'sd0, 32'sd0);
        send_word(RANGE_MIN, RANGE_MIN);
        send_word(RANGE_MAX, RANGE_MAX);
        send_word(-32'sd1, 32'sd0);
        send_word(32'sd0, -32'sd1);
        send_word(32'sd100, -32'sd100);
        drain();

        // zero seed behaves as one
        load_seed(31'd0, 31'd0, 1'b0);
        send_word(RANGE_MIN, RANGE_MAX);
        send_word(32'sd0, 32'sd1000);
        drain();

        // seed equal to the first modulus: first generator stuck at zero
        load_seed(31'(sclr_pkg::MOD_A), 31'd0, 1'b0);
        send_word(RANGE_MIN, RANGE_MAX);
        send_word(RANGE_MAX, RANGE_MIN);
        send_word(32'sd0, 32'sd10);
        drain();

        // seed equal to the second modulus: second generator stuck at zero
        load_seed(31'(sclr_pkg::MOD_B), 31'd0, 1'b0);
        send_word(RANGE_MIN, RANGE_MAX);
        send_word(-32'sd5, 32'sd5);
        send_word(RANGE_MAX, 32'sd0);
        drain();

        // all-ones seed, written over a decoy seed
        load_seed(31'h7FFF_FFFF, 31'h2AAA_AAAA, 1'b1);
        send_word(RANGE_MIN, RANGE_MAX);
        send_word(32'sd1, 32'sd2);
        send_word(RANGE_MIN, 32'sd0);
        drain();

        // random phases: fresh seed each time, small seeds now and then
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            seed = ($urandom_range(0, 3) == 0) ? 31'($urandom_range(0, 20)) : 31'($urandom);
            load_seed(seed, 31'($urandom), $urandom_range(0, 3) == 0);
            repeat (RANDOM_PER_PHASE) begin
                random_bounds(lo, hi);
                send_word(lo, hi);
            end
            drain();
        end

        // wait for any stray word to show up
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0)
            $display("shuffled_combined_lcg_rng_top: match");
        else
            $display("shuffled_combined_lcg_rng_top: mismatch");
        $finish;
    end

endmodule
